FILE: design/fsw_pkg.sv
// ----------------------------------------------------------------------------
// File semaphore wait queues package
// Shared types and constants for the file semaphore block.
// ----------------------------------------------------------------------------
package fsw_pkg;

    localparam int NUM_FILES   = 16;
    localparam int QUEUE_DEPTH = 16;
    localparam int PID_BITS    = 8;
    localparam int FILE_BITS   = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int FILL_BITS   = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_BITS   = FILE_BITS + QPTR_BITS;

    typedef enum logic [1:0] {
        CMD_CREATE  = 2'd0,
        CMD_WAIT    = 2'd1,
        CMD_SIGNAL  = 2'd2,
        CMD_UNBLOCK = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_BLOCKED = 3'd1,
        ST_READY   = 3'd2,
        ST_NOFILE  = 3'd3,
        ST_FULL    = 3'd4
    } status_t;

    typedef struct packed {
        cmd_t                 cmd;
        logic [FILE_BITS-1:0] file;
        logic [PID_BITS-1:0]  pid;
    } req_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_EXEC,
        BK_SCAN,
        BK_SHIFT,
        BK_DONE
    } bk_state_t;

endpackage

FILE: design/fsw_front.sv
// ----------------------------------------------------------------------------
// File semaphore front end
// Accepts request words into a two-entry queue toward the back end.
// ----------------------------------------------------------------------------
module fsw_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_command,
    input  logic [3:0]       s_file_index,
    input  logic [7:0]       s_process_id,
    output logic             q_valid,
    input  logic             q_ready,
    output fsw_pkg::req_t    q_req
);
    import fsw_pkg::*;

    req_t       mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;
    assign q_req   = mem_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= '{cmd: cmd_t'(s_command), file: s_file_index,
                                   pid: s_process_id[PID_BITS-1:0]};
        end
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            if (push) wptr_reg <= ~wptr_reg;
            if (pop)  rptr_reg <= ~rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg != 2'd3)
        else $error("Request queue count out of range.");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0) |-> !pop) else $error("Pop from empty queue.");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 2'd1))
        else $error("Queue count did not grow.");

endmodule

FILE: design/fsw_back.sv
// ----------------------------------------------------------------------------
// File semaphore back end
// Executes create, wait, signal and unblock against the file table and the
// blocked-pid memory, then holds the result word in an output register.
// ----------------------------------------------------------------------------
module fsw_back (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     q_valid,
    output logic                     q_ready,
    input  fsw_pkg::req_t            q_req,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [2:0]               m_status,
    output logic [7:0]               m_ready_process,
    output logic                     m_waiters_pending
);
    import fsw_pkg::*;

    logic [PID_BITS-1:0]        store_mem [NUM_FILES*QUEUE_DEPTH];
    logic [PID_BITS-1:0]        rd_reg;
    logic [NUM_FILES-1:0]       exists_reg;
    logic signed [7:0]          count_reg [NUM_FILES];
    logic [QPTR_BITS-1:0]       head_reg  [NUM_FILES];
    logic [FILL_BITS-1:0]       fill_reg  [NUM_FILES];

    bk_state_t                  state_reg, state_next;
    req_t                       req_reg;
    logic [FILL_BITS-1:0]       idx_reg;
    logic                       hit_reg;
    logic                       out_valid_reg;
    status_t                    out_status_reg;
    logic [PID_BITS-1:0]        out_pid_reg;

    logic [FILE_BITS-1:0]       f;
    logic signed [7:0]          cnt;
    logic [FILL_BITS-1:0]       fill;
    logic [QPTR_BITS-1:0]       head;
    logic signed [7:0]          dec_c, inc_c;
    logic [ADDR_BITS-1:0]       rd_addr;
    logic [QPTR_BITS-1:0]       pos;
    logic                       blk_wr;

    assign f     = req_reg.file;
    assign cnt   = count_reg[f];
    assign fill  = fill_reg[f];
    assign head  = head_reg[f];
    assign dec_c = (cnt == -8'sd128) ? cnt : cnt - 8'sd1;
    assign inc_c = (cnt == 8'sd127) ? cnt : cnt + 8'sd1;

    assign blk_wr = (state_reg == BK_EXEC) && (req_reg.cmd == CMD_WAIT) && exists_reg[f] &&
                    dec_c[7] && (fill < FILL_BITS'(QUEUE_DEPTH));

    assign q_ready           = (state_reg == BK_IDLE) && !out_valid_reg;
    assign m_valid           = out_valid_reg;
    assign m_status          = out_status_reg;
    assign m_ready_process   = 8'(out_pid_reg);
    assign m_waiters_pending = exists_reg[f] && cnt[7];

    // The read is issued ahead of use: the head at request entry, then the
    // next scan entry, then the entry two ahead of the one being compacted.
    always_comb begin
        pos = head + QPTR_BITS'(idx_reg);
        if (state_reg == BK_EXEC) pos = head;
        if (state_reg == BK_SCAN) pos = pos + QPTR_BITS'(1);
        if (state_reg == BK_SHIFT) pos = pos + QPTR_BITS'(2);
        if (state_reg == BK_IDLE) pos = head_reg[q_req.file];
        rd_addr = {(state_reg == BK_IDLE) ? q_req.file : f, pos};
    end

    always_ff @(posedge aclk) begin
        rd_reg <= store_mem[rd_addr];
        if (blk_wr) store_mem[{f, head + QPTR_BITS'(fill)}] <= req_reg.pid;
        if (state_reg == BK_SHIFT) store_mem[{f, head + QPTR_BITS'(idx_reg)}] <= rd_reg;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:  if (q_valid && q_ready) state_next = BK_EXEC;
            BK_EXEC:  begin
                if (req_reg.cmd == CMD_UNBLOCK && exists_reg[f] && fill != '0)
                    state_next = BK_SCAN;
                else
                    state_next = BK_DONE;
            end
            BK_SCAN:  begin
                if (rd_reg == req_reg.pid) begin
                    if (idx_reg + 1'b1 >= fill) state_next = BK_DONE;
                    else state_next = BK_SHIFT;
                end else if (idx_reg + 1'b1 >= fill) begin
                    state_next = BK_DONE;
                end
            end
            BK_SHIFT: if (idx_reg + FILL_BITS'(2) >= fill) state_next = BK_DONE;
            BK_DONE:  if (!out_valid_reg) state_next = BK_IDLE;
            default:  state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            exists_reg    <= '0;
            req_reg       <= '0;
            for (int i = 0; i < NUM_FILES; i++) begin
                count_reg[i] <= '0;
                head_reg[i]  <= '0;
                fill_reg[i]  <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (q_valid && q_ready) req_reg <= q_req;
            if (state_reg == BK_EXEC) begin
                idx_reg <= '0;
                hit_reg <= 1'b0;
                out_pid_reg <= '0;
                out_status_reg <= ST_OK;
                if (req_reg.cmd == CMD_CREATE) begin
                    exists_reg[f] <= 1'b1;
                    count_reg[f]  <= 8'sd1;
                    head_reg[f]   <= '0;
                    fill_reg[f]   <= '0;
                end else if (!exists_reg[f]) begin
                    out_status_reg <= ST_NOFILE;
                end else if (req_reg.cmd == CMD_WAIT) begin
                    if (dec_c[7]) begin
                        if (fill >= FILL_BITS'(QUEUE_DEPTH)) begin
                            out_status_reg <= ST_FULL;
                        end else begin
                            fill_reg[f]  <= fill + 1'b1;
                            count_reg[f] <= dec_c;
                            out_status_reg <= ST_BLOCKED;
                        end
                    end else begin
                        count_reg[f] <= dec_c;
                    end
                end else if (req_reg.cmd == CMD_SIGNAL) begin
                    count_reg[f] <= inc_c;
                    if ((inc_c[7] || inc_c == 8'sd0) && fill != '0) begin
                        out_pid_reg    <= rd_reg;
                        head_reg[f]    <= head + QPTR_BITS'(1);
                        fill_reg[f]    <= fill - 1'b1;
                        out_status_reg <= ST_READY;
                    end
                end
            end
            if (state_reg == BK_SCAN) begin
                if (rd_reg == req_reg.pid) begin
                    hit_reg <= 1'b1;
                    out_pid_reg <= req_reg.pid;
                    out_status_reg <= ST_READY;
                    if (idx_reg + 1'b1 >= fill) fill_reg[f] <= fill - 1'b1;
                end else begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            if (state_reg == BK_SHIFT) begin
                idx_reg <= idx_reg + 1'b1;
                if (idx_reg + FILL_BITS'(2) >= fill) fill_reg[f] <= fill - 1'b1;
            end
            if (state_reg == BK_DONE && !out_valid_reg) out_valid_reg <= 1'b1;
            else if (out_valid_reg && m_ready) out_valid_reg <= 1'b0;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_SHIFT) |-> hit_reg)
        else $error("Compaction without a matching pid.");
    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg[f] <= FILL_BITS'(QUEUE_DEPTH)) else $error("Queue overfilled.");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |=> out_valid_reg)
        else $error("Result word dropped.");

endmodule

FILE: design/file_semaphore_wait_queues_top.sv
// ----------------------------------------------------------------------------
// File semaphore wait queues, top level
// Counting semaphores per file with FIFO queues of blocked process ids.
// ----------------------------------------------------------------------------
// Each request word yields one result word. A create, wait or signal passes
// through the back end's read-modify-write sequencer, EXEC then DONE; an
// unblock also steps through SCAN per queue entry scanned and SHIFT per
// entry compacted in the pid memory.
// A two-entry request queue lets new words enter while a result waits.
module file_semaphore_wait_queues_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_command,
    input  logic [3:0] s_file_index,
    input  logic [7:0] s_process_id,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_status,
    output logic [7:0] m_ready_process,
    output logic       m_waiters_pending
);
    import fsw_pkg::*;

    logic q_valid, q_ready;
    req_t q_req;

    fsw_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_command, .s_file_index,
        .s_process_id, .q_valid, .q_ready, .q_req
    );

    fsw_back u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_req, .m_valid, .m_ready,
        .m_status, .m_ready_process, .m_waiters_pending
    );

endmodule
